// File: hdl/awat_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package awat_pkg;

	localparam int MAX_SAMPLES_DEF     = 1024;
	localparam int ANGLE_FRAC_BITS_DEF = 8;
	localparam int SUM_W_DEF           = 28;
	localparam int CNT_W_DEF           = 11;

	localparam int RAW_W   = 16;
	localparam int BIAS_W  = 17;
	localparam int SCALE_W = 16;
	localparam int MEAN_W  = 18;
	localparam int SQ_W    = 36;
	localparam int ROOT_W  = 28;
	localparam int RAD_W   = 56;
	localparam int CORD_W  = 32;
	localparam int ANG_W   = 27;
	localparam int TILT_W  = 16;
	localparam int USED_W  = 11;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 17;
	localparam int CORD_STEPS = 18;

	localparam logic [CFG_IDX_W-1:0] REG_BIAS_X  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BIAS_Y  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BIAS_Z  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_X = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_Z = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_CALIB   = 3'd6;

	localparam logic [SCALE_W-1:0] SCALE_ONE = 16'd16384;

	localparam logic signed [ANG_W-1:0] DEG90  = 27'sd5898240;
	localparam logic signed [ANG_W-1:0] DEG180 = 27'sd11796480;

	localparam int ATAN_DEG16 [CORD_STEPS] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335, 14668,
		7334, 3667, 1833, 917, 458, 229, 115, 57, 29
	};

	typedef struct packed {
		logic corr_start;
		logic acc_en;
		logic clr;
		logic div_start;
	} lane_ctl_t;

	function automatic logic signed [CORD_W-1:0] tshift(
		input logic signed [CORD_W-1:0] v,
		input logic [4:0] n
	);
		logic signed [CORD_W-1:0] nv;
		nv = -v;
		if (v[CORD_W-1]) begin
			tshift = -(nv >>> n);
		end else begin
			tshift = v >>> n;
		end
	endfunction

endpackage
`default_nettype wire

// File: hdl/awat_lane.sv
`timescale 1ns / 1ps
`default_nettype none
module awat_lane import awat_pkg::*; #(
	parameter int SUMW = SUM_W_DEF,
	parameter int CW   = CNT_W_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire lane_ctl_t                 ctl,
	input  wire logic signed [RAW_W-1:0]   raw,
	input  wire logic signed [BIAS_W-1:0]  bias,
	input  wire logic        [SCALE_W-1:0] scale,
	input  wire logic                      calib,
	input  wire logic        [CW-1:0]      count,
	output logic signed [MEAN_W-1:0]       mean,
	output logic        [SQ_W-1:0]         sq,
	output logic                           done
);

	localparam int DW  = SUMW + 1;
	localparam int DCW = $clog2(DW + 1);

	typedef enum logic [3:0] {
		L_IDLE = 4'b0001,
		L_DIV  = 4'b0010,
		L_MEAN = 4'b0100,
		L_SQ   = 4'b1000
	} lane_state_t;

	lane_state_t state_q;

	logic signed [MEAN_W-1:0] diff;
	logic signed [34:0]       prod;
	logic signed [34:0]       prod_s1;
	logic signed [RAW_W-1:0]  raw_s1;
	logic                     calib_s1;
	logic signed [34:0]       rnd;
	logic signed [MEAN_W-1:0] corr;
	logic signed [SUMW-1:0]   sum_q;
	logic        [SUMW-1:0]   abs_sum;
	logic        [SUMW:0]     mag;
	logic        [SUMW:0]     dvd_q;
	logic        [CW-1:0]     rem_q;
	logic        [CW:0]       rem2;
	logic                     ge;
	logic        [DCW-1:0]    cnt_q;
	logic                     neg_q;
	logic signed [MEAN_W-1:0] mean_q;
	logic signed [SQ_W-1:0]   sq_full;
	logic        [SQ_W-1:0]   sq_q;
	logic                     done_q;

	assign diff = MEAN_W'(raw) - MEAN_W'(bias);
	assign prod = diff * $signed({1'b0, scale});
	assign rnd  = (prod_s1 + 35'sd8192) >>> 14;

	always_comb begin
		if (!calib_s1) begin
			corr = MEAN_W'(raw_s1);
		end else if (rnd > 35'sd131071) begin
			corr = 18'sd131071;
		end else if (rnd < -35'sd131072) begin
			corr = -18'sd131072;
		end else begin
			corr = rnd[MEAN_W-1:0];
		end
	end

	assign abs_sum = sum_q[SUMW-1] ? SUMW'(-sum_q) : SUMW'(sum_q);
	assign mag     = {1'b0, abs_sum} + (SUMW+1)'(count >> 1);
	assign rem2    = {rem_q, dvd_q[SUMW]};
	assign ge      = rem2 >= {1'b0, count};
	assign sq_full = mean_q * mean_q;

	always_ff @(posedge clk) begin
		if (ctl.corr_start) begin
			prod_s1  <= prod;
			raw_s1   <= raw;
			calib_s1 <= calib;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			state_q <= L_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (ctl.clr) begin
				sum_q <= '0;
			end else if (ctl.acc_en) begin
				sum_q <= sum_q + SUMW'(corr);
			end
			case (state_q)
				L_IDLE: begin
					if (ctl.div_start) begin
						state_q <= L_DIV;
					end
				end
				L_DIV: begin
					if (cnt_q == '0) begin
						state_q <= L_MEAN;
					end
				end
				L_MEAN: begin
					state_q <= L_SQ;
				end
				L_SQ: begin
					done_q  <= 1'b1;
					state_q <= L_IDLE;
				end
				default: begin
					state_q <= L_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			L_IDLE: begin
				dvd_q <= mag;
				rem_q <= '0;
				neg_q <= sum_q[SUMW-1];
				cnt_q <= DCW'(DW - 1);
			end
			L_DIV: begin
				rem_q <= ge ? CW'(rem2 - {1'b0, count}) : CW'(rem2);
				dvd_q <= {dvd_q[SUMW-1:0], ge};
				cnt_q <= cnt_q - 1'b1;
			end
			L_MEAN: begin
				if (!neg_q) begin
					mean_q <= (dvd_q > (SUMW+1)'(131071)) ? 18'sd131071
						: $signed(dvd_q[MEAN_W-1:0]);
				end else begin
					mean_q <= (dvd_q >= (SUMW+1)'(131072)) ? -18'sd131072
						: -$signed(dvd_q[MEAN_W-1:0]);
				end
			end
			L_SQ: begin
				sq_q <= SQ_W'(sq_full);
			end
			default: begin
				rem_q <= '0;
			end
		endcase
	end

	assign mean = mean_q;
	assign sq   = sq_q;
	assign done = done_q;

endmodule
`default_nettype wire

// File: hdl/awat_tilt.sv
`timescale 1ns / 1ps
`default_nettype none
module awat_tilt import awat_pkg::*; #(
	parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic signed [MEAN_W-1:0] a,
	input  wire logic        [SQ_W-1:0]   sq_b,
	input  wire logic        [SQ_W-1:0]   sq_c,
	output logic             [TILT_W-1:0] angle,
	output logic                          done
);

	localparam int SH = 16 - ANGLE_FRAC_BITS;
	localparam logic [24:0] HALF = 25'(1) << (SH - 1);

	typedef enum logic [4:0] {
		T_IDLE = 5'b00001,
		T_ROOT = 5'b00010,
		T_INIT = 5'b00100,
		T_ROT  = 5'b01000,
		T_END  = 5'b10000
	} tilt_state_t;

	tilt_state_t state_q;

	logic        [RAD_W-1:0]    rad_q;
	logic        [ROOT_W+1:0]   rem_q;
	logic        [ROOT_W-1:0]   root_q;
	logic        [ROOT_W+3:0]   rem2;
	logic        [ROOT_W+1:0]   trial;
	logic                       take;
	logic        [4:0]          it_q;
	logic signed [CORD_W-1:0]   x_q;
	logic signed [CORD_W-1:0]   y_q;
	logic signed [ANG_W-1:0]    ang_q;
	logic signed [CORD_W-1:0]   ax;
	logic signed [CORD_W-1:0]   dx;
	logic signed [CORD_W-1:0]   dy;
	logic        [24:0]         angc;
	logic        [24:0]         r;
	logic        [TILT_W-1:0]   angle_q;
	logic                       done_q;

	assign rem2  = {rem_q, rad_q[RAD_W-1:RAD_W-2]};
	assign trial = {root_q, 2'b01};
	assign take  = rem2 >= (ROOT_W+4)'(trial);
	assign ax    = CORD_W'(a) <<< 10;
	assign dx    = tshift(y_q, it_q);
	assign dy    = tshift(x_q, it_q);

	always_comb begin
		if (ang_q < 0) begin
			angc = '0;
		end else if (ang_q > DEG180) begin
			angc = 25'(DEG180);
		end else begin
			angc = 25'(ang_q);
		end
	end

	assign r = (angc + HALF) >> SH;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				T_IDLE: begin
					if (start) begin
						state_q <= T_ROOT;
					end
				end
				T_ROOT: begin
					if (it_q == '0) begin
						state_q <= T_INIT;
					end
				end
				T_INIT: begin
					state_q <= T_ROT;
				end
				T_ROT: begin
					if (it_q == 5'(CORD_STEPS - 1)) begin
						state_q <= T_END;
					end
				end
				T_END: begin
					done_q  <= 1'b1;
					state_q <= T_IDLE;
				end
				default: begin
					state_q <= T_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			T_IDLE: begin
				rad_q  <= RAD_W'(sq_b + sq_c) << 20;
				rem_q  <= '0;
				root_q <= '0;
				it_q   <= 5'(ROOT_W - 1);
			end
			T_ROOT: begin
				rad_q  <= rad_q << 2;
				rem_q  <= take ? (ROOT_W+2)'(rem2 - (ROOT_W+4)'(trial))
					: (ROOT_W+2)'(rem2);
				root_q <= {root_q[ROOT_W-2:0], take};
				it_q   <= it_q - 1'b1;
			end
			T_INIT: begin
				if (a < 0) begin
					x_q   <= CORD_W'(root_q);
					y_q   <= -ax;
					ang_q <= DEG90;
				end else begin
					x_q   <= ax;
					y_q   <= CORD_W'(root_q);
					ang_q <= '0;
				end
				it_q <= '0;
			end
			T_ROT: begin
				if (y_q > 0) begin
					x_q   <= x_q + dx;
					y_q   <= y_q - dy;
					ang_q <= ang_q + ANG_W'(ATAN_DEG16[it_q]);
				end else begin
					x_q   <= x_q - dx;
					y_q   <= y_q + dy;
					ang_q <= ang_q - ANG_W'(ATAN_DEG16[it_q]);
				end
				it_q <= it_q + 1'b1;
			end
			T_END: begin
				angle_q <= (|r[24:16]) ? 16'hFFFF : r[15:0];
			end
			default: begin
				it_q <= '0;
			end
		endcase
	end

	assign angle = angle_q;
	assign done  = done_q;

endmodule
`default_nettype wire

// File: hdl/accel_window_average_tilt_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Handshake              Content
// in        input      in_valid / in_ready    operation, raw_x, raw_y, raw_z
// out       output     out_valid / out_ready  means, tilts, flags, samples_used
// cfg       input      cfg_we                 cfg_index, cfg_data
// An add item goes through the gain multiply, then saturation and accumulation.
// A finish item on a non-empty window runs a bit-serial divider per axis, a square,
// a 28-step square root and 18 CORDIC steps per axis.
// Reset clears the window and sets the gains to one and correction off.
// A result held by out_ready low does not stop add items, but the next finish item waits in ST_OUT with in_ready low.
module accel_window_average_tilt_unit import awat_pkg::*; #(
	parameter int MAX_SAMPLES     = MAX_SAMPLES_DEF,
	parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic                        operation,
	input  wire logic signed [RAW_W-1:0]     raw_x,
	input  wire logic signed [RAW_W-1:0]     raw_y,
	input  wire logic signed [RAW_W-1:0]     raw_z,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic signed [MEAN_W-1:0]         mean_x,
	output logic signed [MEAN_W-1:0]         mean_y,
	output logic signed [MEAN_W-1:0]         mean_z,
	output logic        [TILT_W-1:0]         tilt_x,
	output logic        [TILT_W-1:0]         tilt_y,
	output logic        [TILT_W-1:0]         tilt_z,
	output logic                             averages_valid,
	output logic                             tilt_valid,
	output logic        [USED_W-1:0]         samples_used,
	output logic                             window_overflow,
	input  wire logic                        cfg_we,
	input  wire logic        [CFG_IDX_W-1:0] cfg_index,
	input  wire logic        [CFG_DAT_W-1:0] cfg_data
);

	localparam int SUMW = $clog2(MAX_SAMPLES) + 18;
	localparam int CW   = $clog2(MAX_SAMPLES + 1);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_ADD  = 5'b00010,
		ST_DIV  = 5'b00100,
		ST_TILT = 5'b01000,
		ST_OUT  = 5'b10000
	} top_state_t;

	top_state_t state_q;

	logic signed [BIAS_W-1:0]  bias_q [3];
	logic        [SCALE_W-1:0] scale_q [3];
	logic                      calib_q;
	logic        [CW-1:0]      count_q;
	logic                      dropped_q;
	logic                      accept;
	logic                      out_load;
	lane_ctl_t                 ctl;
	logic signed [RAW_W-1:0]   raw [3];
	logic signed [MEAN_W-1:0]  mean [3];
	logic        [SQ_W-1:0]    sq [3];
	logic        [2:0]         lane_done;
	logic        [TILT_W-1:0]  angle [3];
	logic        [2:0]         tilt_done;
	logic                      tilt_start;
	logic                      empty;
	logic                      tv;
	logic                      out_valid_q;

	assign raw[0] = raw_x;
	assign raw[1] = raw_y;
	assign raw[2] = raw_z;

	assign in_ready   = state_q == ST_IDLE;
	assign accept     = in_valid && in_ready;
	assign out_load   = (state_q == ST_OUT) && (!out_valid_q || out_ready);
	assign tilt_start = (state_q == ST_DIV) && (&lane_done);
	assign empty      = count_q == '0;
	assign tv         = (mean[0] != '0) || (mean[1] != '0) || (mean[2] != '0);

	always_comb begin
		ctl.corr_start = accept && !operation;
		ctl.acc_en     = (state_q == ST_ADD) && (count_q < CW'(MAX_SAMPLES));
		ctl.clr        = out_load;
		ctl.div_start  = accept && operation && (count_q != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				bias_q[k]  <= '0;
				scale_q[k] <= SCALE_ONE;
			end
			calib_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BIAS_X:  bias_q[0]  <= cfg_data;
				REG_BIAS_Y:  bias_q[1]  <= cfg_data;
				REG_BIAS_Z:  bias_q[2]  <= cfg_data;
				REG_SCALE_X: scale_q[0] <= cfg_data[SCALE_W-1:0];
				REG_SCALE_Y: scale_q[1] <= cfg_data[SCALE_W-1:0];
				REG_SCALE_Z: scale_q[2] <= cfg_data[SCALE_W-1:0];
				REG_CALIB:   calib_q    <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			dropped_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && !operation) begin
						state_q <= ST_ADD;
					end else if (accept && operation) begin
						state_q <= empty ? ST_OUT : ST_DIV;
					end
				end
				ST_ADD: begin
					if (ctl.acc_en) begin
						count_q <= count_q + 1'b1;
					end else begin
						dropped_q <= 1'b1;
					end
					state_q <= ST_IDLE;
				end
				ST_DIV: begin
					if (&lane_done) begin
						state_q <= ST_TILT;
					end
				end
				ST_TILT: begin
					if (&tilt_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						out_valid_q <= 1'b1;
						count_q     <= '0;
						dropped_q   <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			mean_x          <= empty ? '0 : mean[0];
			mean_y          <= empty ? '0 : mean[1];
			mean_z          <= empty ? '0 : mean[2];
			tilt_x          <= (empty || !tv) ? '0 : angle[0];
			tilt_y          <= (empty || !tv) ? '0 : angle[1];
			tilt_z          <= (empty || !tv) ? '0 : angle[2];
			averages_valid  <= !empty;
			tilt_valid      <= !empty && tv;
			samples_used    <= USED_W'(count_q);
			window_overflow <= dropped_q;
		end
	end

	assign out_valid = out_valid_q;

	for (genvar g = 0; g < 3; g++) begin : g_lane
		awat_lane #(
			.SUMW (SUMW),
			.CW   (CW)
		) u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.raw    (raw[g]),
			.bias   (bias_q[g]),
			.scale  (scale_q[g]),
			.calib  (calib_q),
			.count  (count_q),
			.mean   (mean[g]),
			.sq     (sq[g]),
			.done   (lane_done[g])
		);

		awat_tilt #(
			.ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
		) u_tilt (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (tilt_start),
			.a      (mean[g]),
			.sq_b   (sq[(g + 1) % 3]),
			.sq_c   (sq[(g + 2) % 3]),
			.angle  (angle[g]),
			.done   (tilt_done[g])
		);
	end

endmodule
`default_nettype wire

// File: hdl/awat_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module awat_checker import awat_pkg::*; (
	input wire logic                     clk,
	input wire logic                     arst_n,
	input wire logic                     out_valid,
	input wire logic                     out_ready,
	input wire logic signed [MEAN_W-1:0] mean_x,
	input wire logic        [TILT_W-1:0] tilt_x,
	input wire logic        [TILT_W-1:0] tilt_y,
	input wire logic        [TILT_W-1:0] tilt_z,
	input wire logic                     averages_valid,
	input wire logic                     tilt_valid,
	input wire logic        [USED_W-1:0] samples_used
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before transfer");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(mean_x))
		else $error("stalled result changed");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !averages_valid |-> !tilt_valid && samples_used == '0)
		else $error("empty window reported samples or tilt");

	a_no_tilt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !tilt_valid |-> tilt_x == '0 && tilt_y == '0 && tilt_z == '0)
		else $error("tilt angles nonzero without valid tilt");

endmodule

bind accel_window_average_tilt_unit awat_checker u_awat_checker (.*);
`default_nettype wire

// File: tb/tb_accel_window_average_tilt_unit.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_accel_window_average_tilt_unit;
	import awat_pkg::*;

	localparam logic OP_ADD    = 1'b0;
	localparam logic OP_FINISH = 1'b1;
	localparam int SETTLE_CYCLES = 120;

	typedef struct {
		logic signed [MEAN_W-1:0] mx, my, mz;
		logic [TILT_W-1:0] tx, ty, tz;
		logic av, tv;
		logic [USED_W-1:0] used;
		logic ovf;
	} report_t;

	typedef struct {
		logic op;
		int x, y, z;
		bit known;
		report_t rep;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic operation = OP_ADD;
	logic signed [RAW_W-1:0] raw_x = '0, raw_y = '0, raw_z = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [MEAN_W-1:0] mean_x, mean_y, mean_z;
	logic [TILT_W-1:0] tilt_x, tilt_y, tilt_z;
	logic averages_valid, tilt_valid, window_overflow;
	logic [USED_W-1:0] samples_used;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_data = '0;

	report_t pending_reports[$];
	int errors = 0;
	bit in_calm = 0, out_calm = 0;

	longint acc_x, acc_y, acc_z;
	int acc_count;
	bit acc_dropped;
	longint bias[3];
	longint gain[3];
	bit calib_on;

	always #6 clk = ~clk;

	accel_window_average_tilt_unit dut (.*);

	function automatic longint sat18(longint v);
		if (v > 131071) return 131071;
		if (v < -131072) return -131072;
		return v;
	endfunction

	function automatic longint corrected(longint raw, int axis);
		if (!calib_on) return raw;
		return sat18(((raw - bias[axis]) * gain[axis] + 8192) >>> 14);
	endfunction

	function automatic longint mean_of(longint s, int n);
		longint mag, q;
		mag = (s < 0) ? -s : s;
		q = (mag + n / 2) / n;
		return sat18((s < 0) ? -q : q);
	endfunction

	function automatic longint root_floor(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic longint shift_trunc(longint v, int n);
		if (v >= 0) return v >>> n;
		return -((-v) >>> n);
	endfunction

	function automatic longint tilt_angle(longint a, longint b, longint c);
		longint x, y, ang, t, dx, dy;
		int sh;
		x = a * 1024;
		y = root_floor(longint'(b * b + c * c) << 20);
		ang = 0;
		if (x < 0) begin
			t = x;
			x = y;
			y = -t;
			ang = 90 * 65536;
		end
		for (int i = 0; i < CORD_STEPS; i++) begin
			dx = shift_trunc(y, i);
			dy = shift_trunc(x, i);
			if (y > 0) begin
				x += dx; y -= dy; ang += ATAN_DEG16[i];
			end else begin
				x -= dx; y += dy; ang -= ATAN_DEG16[i];
			end
		end
		if (ang < 0) ang = 0;
		if (ang > 180 * 65536) ang = 180 * 65536;
		sh = 16 - ANGLE_FRAC_BITS_DEF;
		ang = (ang + (longint'(1) << (sh - 1))) >>> sh;
		return (ang > 65535) ? 65535 : ang;
	endfunction

	function automatic void clear_window();
		acc_x = 0; acc_y = 0; acc_z = 0;
		acc_count = 0;
		acc_dropped = 0;
	endfunction

	function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] d);
		case (idx)
			REG_BIAS_X:  bias[0] = longint'($signed(d));
			REG_BIAS_Y:  bias[1] = longint'($signed(d));
			REG_BIAS_Z:  bias[2] = longint'($signed(d));
			REG_SCALE_X: gain[0] = d[SCALE_W-1:0];
			REG_SCALE_Y: gain[1] = d[SCALE_W-1:0];
			REG_SCALE_Z: gain[2] = d[SCALE_W-1:0];
			REG_CALIB:   calib_on = d[0];
			default: ;
		endcase
	endfunction

	// Updates the window and returns 1 with the report when the item is a finish.
	function automatic bit window_step(logic op, int x, int y, int z, output report_t r);
		longint mx, my, mz;
		r = '{default: '0};
		if (op == OP_ADD) begin
			if (acc_count >= MAX_SAMPLES_DEF) begin
				acc_dropped = 1;
			end else begin
				acc_x += corrected(x, 0);
				acc_y += corrected(y, 1);
				acc_z += corrected(z, 2);
				acc_count++;
			end
			return 0;
		end
		if (acc_count != 0) begin
			mx = mean_of(acc_x, acc_count);
			my = mean_of(acc_y, acc_count);
			mz = mean_of(acc_z, acc_count);
			r.mx = MEAN_W'(mx); r.my = MEAN_W'(my); r.mz = MEAN_W'(mz);
			r.av = 1;
			r.tv = (mx != 0) || (my != 0) || (mz != 0);
			if (r.tv) begin
				r.tx = TILT_W'(tilt_angle(mx, my, mz));
				r.ty = TILT_W'(tilt_angle(my, mx, mz));
				r.tz = TILT_W'(tilt_angle(mz, mx, my));
			end
			r.used = USED_W'(acc_count);
		end
		r.ovf = acc_dropped;
		clear_window();
		return 1;
	endfunction

	function automatic int pick_gap(bit calm);
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_item(logic op, int x, int y, int z, bit known, report_t typed);
		int gap;
		report_t r;
		gap = pick_gap(in_calm);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		raw_x <= RAW_W'(x);
		raw_y <= RAW_W'(y);
		raw_z <= RAW_W'(z);
		do @(posedge clk); while (!in_ready);
		if (window_step(op, x, y, z, r)) pending_reports.push_back(known ? typed : r);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_all(logic [CFG_DAT_W-1:0] vals[7], bit with_unknown);
		for (int i = 0; i < 7; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= CFG_IDX_W'(i);
			cfg_data <= vals[i];
			@(posedge clk);
			apply_reg(CFG_IDX_W'(i), vals[i]);
		end
		if (with_unknown) begin
			cfg_index <= CFG_IDX_W'(REG_CALIB + 1);
			cfg_data <= CFG_DAT_W'($urandom());
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	function automatic int random_raw();
		case ($urandom_range(0, 5))
			0: return -32768;
			1: return 32767;
			2: return $urandom_range(0, 200) - 100;
			default: return int'($signed(16'($urandom())));
		endcase
	endfunction

	task automatic random_windows(int n_items);
		int sent, len;
		report_t none;
		none = '{default: '0};
		sent = 0;
		while (sent < n_items) begin
			in_calm = ($urandom_range(0, 9) == 0);
			len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
			for (int k = 0; k < len; k++)
				send_item(OP_ADD, random_raw(), random_raw(), random_raw(), 0, none);
			send_item(OP_FINISH, random_raw(), random_raw(), random_raw(), 0, none);
			sent += len + 1;
		end
		in_calm = 0;
	endtask

	task automatic check_field(string name, longint e, longint a);
		if (e != a) begin
			$error("%s expected %0d actual %0d", name, e, a);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		out_calm <= ($urandom_range(0, 199) == 0) ? ~out_calm : out_calm;
		out_ready <= out_calm ? 1'b1 : (pick_gap(0) == 0);
	end

	always @(posedge clk) begin
		report_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_reports.size() == 0) begin
				$error("result with no expectation waiting");
				errors++;
			end else begin
				e = pending_reports.pop_front();
				check_field("mean_x", e.mx, mean_x);
				check_field("mean_y", e.my, mean_y);
				check_field("mean_z", e.mz, mean_z);
				check_field("tilt_x", e.tx, tilt_x);
				check_field("tilt_y", e.ty, tilt_y);
				check_field("tilt_z", e.tz, tilt_z);
				check_field("averages_valid", e.av, averages_valid);
				check_field("tilt_valid", e.tv, tilt_valid);
				check_field("samples_used", e.used, samples_used);
				check_field("window_overflow", e.ovf, window_overflow);
			end
		end
	end

	initial begin
		#20ms;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		stim_row_t rows[$];
		report_t none, empty_rep, zero_rep;
		logic [CFG_DAT_W-1:0] vals[7];

		clear_window();
		bias = '{0, 0, 0};
		gain = '{SCALE_ONE, SCALE_ONE, SCALE_ONE};
		calib_on = 0;
		none = '{default: '0};
		empty_rep = none;
		zero_rep = none;
		zero_rep.av = 1;
		zero_rep.used = 1;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		rows = '{
			'{OP_FINISH, 0, 0, 0, 1, empty_rep},
			'{OP_ADD, 0, 0, 0, 0, none},
			'{OP_FINISH, 0, 0, 0, 1, zero_rep},
			'{OP_ADD, 32767, 32767, 32767, 0, none},
			'{OP_ADD, -32768, -32768, -32768, 0, none},
			'{OP_FINISH, -1, -1, -1, 0, none},
			'{OP_ADD, 16384, 0, 0, 0, none},
			'{OP_FINISH, 0, 0, 0, 0, none},
			'{OP_ADD, 0, -16384, 0, 0, none},
			'{OP_FINISH, 0, 0, 0, 0, none},
			'{OP_ADD, 0, 0, -16384, 0, none},
			'{OP_FINISH, 0, 0, 0, 0, none},
			'{OP_ADD, 1, -1, 0, 0, none},
			'{OP_ADD, 0, 0, 0, 0, none},
			'{OP_FINISH, 0, 0, 0, 0, none},
			'{OP_ADD, -32768, 32767, 1, 0, none},
			'{OP_FINISH, 0, 0, 0, 0, none},
			'{OP_ADD, -1, 1, 3, 0, none},
			'{OP_ADD, 0, 0, 0, 0, none},
			'{OP_FINISH, 32767, -32768, 0, 0, none}
		};
		foreach (rows[i])
			send_item(rows[i].op, rows[i].x, rows[i].y, rows[i].z, rows[i].known, rows[i].rep);

		wait_idle();
		vals = '{17'h10000, 17'h10000, 17'h10000, 17'hFFFF, 17'hFFFF, 17'hFFFF, 17'h1};
		write_all(vals, 1);
		random_windows(150);

		wait_idle();
		vals = '{17'h0FFFF, 17'h0FFFF, 17'h0FFFF, 17'h0, 17'h0, 17'h0, 17'h1};
		write_all(vals, 0);
		random_windows(80);

		for (int p = 0; p < 3; p++) begin
			wait_idle();
			foreach (vals[i]) vals[i] = CFG_DAT_W'($urandom());
			vals[REG_CALIB] = 17'h1;
			write_all(vals, 1);
			random_windows(110);
		end

		// A full window followed by dropped samples.
		wait_idle();
		vals = '{17'h1FF00, 17'h00120, 17'h0, 17'h5000, 17'h3000, 17'h4000, 17'h1};
		write_all(vals, 0);
		for (int k = 0; k < MAX_SAMPLES_DEF + 6; k++)
			send_item(OP_ADD, random_raw(), random_raw(), random_raw(), 0, none);
		send_item(OP_FINISH, 0, 0, 0, 0, none);

		wait_idle();
		vals = '{17'h0, 17'h0, 17'h0, 17'h4000, 17'h4000, 17'h4000, 17'h0};
		write_all(vals, 0);
		random_windows(100);

		wait_idle();
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule
`default_nettype wire

// File: sim.f
hdl/awat_pkg.sv
hdl/awat_lane.sv
hdl/awat_tilt.sv
hdl/accel_window_average_tilt_unit.sv
hdl/awat_checker.sv
tb/tb_accel_window_average_tilt_unit.sv
